// File: design/bitmap_find_first_last_unit_macros.svh
// ----------------------------------------------------------------------------
// bitmap find first/last unit assertion macros
// clocked assertion wrappers shared by the bitmap search design
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIND_FIRST_LAST_UNIT_MACROS_SVH
`define BITMAP_FIND_FIRST_LAST_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// checked at every rising edge, quiet while reset is asserted
`define BFFL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// checked at every rising edge, reset included
`define BFFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BFFL_ASSERT(lbl, clk, rstn, prop, msg)
`define BFFL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: design/bffl_pkg.sv
// ----------------------------------------------------------------------------
// bffl_pkg
// types and constants of the bitmap find first/last unit
// ----------------------------------------------------------------------------
package bffl_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned OFF_W  = 6;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned NUM_W  = 11;
  localparam int unsigned SCAN_W = 6;   // word count of a search, up to 32

  typedef enum logic [2:0] {
    KIND_SET        = 3'd0,
    KIND_GET        = 3'd1,
    KIND_FIND_FIRST = 3'd2,
    KIND_FIND_LAST  = 3'd3,
    KIND_FILL       = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RMW,
    ST_FILL,
    ST_SEARCH,
    ST_RESP
  } state_e;

  // request to the one-word search
  typedef struct packed {
    logic             value;
    logic             from_last;
    logic [OFF_W-1:0] part;      // valid leading bits, 0 means whole word
  } srch_req_t;

  typedef struct packed {
    logic             hit;
    logic [OFF_W-1:0] offset;    // msb-first bit offset in the word
  } srch_res_t;

endpackage

// File: design/bffl_mem.sv
// ----------------------------------------------------------------------------
// bffl_mem
// bit map word store, one write and one registered read port
// ----------------------------------------------------------------------------
module bffl_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [bffl_pkg::WORD_W-1:0]    wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [bffl_pkg::WORD_W-1:0]    rdata_o
);

  logic [bffl_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bffl_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/bffl_word_search.sv
// ----------------------------------------------------------------------------
// bffl_word_search
// finds the first or last matching bit of one map word
// ----------------------------------------------------------------------------
module bffl_word_search (
  input  logic [bffl_pkg::WORD_W-1:0] word_i,
  input  bffl_pkg::srch_req_t         req_i,
  output bffl_pkg::srch_res_t         res_o
);

  logic [bffl_pkg::WORD_W-1:0] mask;
  logic [bffl_pkg::WORD_W-1:0] match;
  logic [bffl_pkg::OFF_W-1:0]  off_first;
  logic [bffl_pkg::OFF_W-1:0]  off_last;

  // leading bits only for the partial tail word
  assign mask  = (req_i.part == '0) ? '1 : ~({bffl_pkg::WORD_W{1'b1}} >> req_i.part);
  assign match = (req_i.value ? word_i : ~word_i) & mask;

  always_comb begin
    off_first = '0;
    off_last  = '0;
    for (int i = bffl_pkg::WORD_W - 1; i >= 0; i--) begin
      if (match[bffl_pkg::WORD_W-1-i]) begin
        off_first = bffl_pkg::OFF_W'(i);
      end
    end
    for (int i = 0; i < bffl_pkg::WORD_W; i++) begin
      if (match[bffl_pkg::WORD_W-1-i]) begin
        off_last = bffl_pkg::OFF_W'(i);
      end
    end
  end

  assign res_o.hit    = |match;
  assign res_o.offset = req_i.from_last ? off_last : off_first;

endmodule

// File: design/bitmap_find_first_last_unit.sv
// ----------------------------------------------------------------------------
// bitmap find first/last unit
// set and get load their result from ST_RMW, unused kinds from ST_RESP, each once
// the result register is free; fill loads it as the last word is written
// a search loads it after reading k words at one per cycle, ending at the first
// word with a hit or the last in range, k at most ceil(min(num_elements, 64*NUM_WORDS)/64)
// one item at a time: the next is taken the cycle after a result is loaded
// after reset a clearing pass writes every word to zero before the first item
// ----------------------------------------------------------------------------
`include "bitmap_find_first_last_unit_macros.svh"

module bitmap_find_first_last_unit #(
  parameter int unsigned NUM_WORDS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    kind_i,
  input  logic [bffl_pkg::IDX_W-1:0]    index_i,
  input  logic                          value_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          bit_res_o,
  output logic                          found_o,
  output logic [bffl_pkg::IDX_W-1:0]    position_o,
  // num_elements write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bffl_pkg::NUM_W-1:0]    cfg_num_elements_i
);

  localparam int unsigned AddrW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned MapBits = NUM_WORDS * bffl_pkg::WORD_W;
  localparam int unsigned WselW   = bffl_pkg::IDX_W - bffl_pkg::OFF_W;

  // control state
  bffl_pkg::state_e              state_q, state_d;
  logic [AddrW-1:0]              cnt_q, cnt_d;
  logic [bffl_pkg::SCAN_W-1:0]   iss_q, iss_d;
  logic                          chk_v_q, chk_v_d;
  logic                          out_valid_q, out_valid_d;
  logic [bffl_pkg::NUM_W-1:0]    num_elements_q;

  // item and search payload
  logic [2:0]                    kind_q;
  logic [bffl_pkg::IDX_W-1:0]    idx_q;
  logic                          val_q;
  logic                          range_q;
  logic [bffl_pkg::SCAN_W-1:0]   nw_q;
  logic [bffl_pkg::OFF_W-1:0]    part_q;
  logic [bffl_pkg::SCAN_W-1:0]   chk_w_q, chk_w_d;
  logic                          chk_last_q, chk_last_d;
  logic                          chk_part_q, chk_part_d;
  logic                          bit_res_q, found_q;
  logic [bffl_pkg::IDX_W-1:0]    position_q;

  // combinational
  logic                          in_accept;
  logic                          out_free;
  logic                          out_load;
  logic                          res_bit, res_found;
  logic [bffl_pkg::IDX_W-1:0]    res_pos;
  logic                          mem_we, mem_re;
  logic [AddrW-1:0]              mem_waddr, mem_raddr;
  logic [bffl_pkg::WORD_W-1:0]   mem_wdata, mem_rdata;
  logic [bffl_pkg::NUM_W-1:0]    lim;
  logic [bffl_pkg::SCAN_W-1:0]   nw_calc;
  logic                          in_range;
  logic [bffl_pkg::SCAN_W-1:0]   scan_word;
  logic                          from_last;
  logic                          terminal;
  logic [bffl_pkg::WORD_W-1:0]   bit_mask;
  logic                          sel_bit;
  bffl_pkg::srch_req_t           srch_req;
  bffl_pkg::srch_res_t           srch_res;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != bffl_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // result register frees when empty or taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // search limit saturated to the map size, then in words and tail bits
  assign lim     = (32'(num_elements_q) > MapBits) ? bffl_pkg::NUM_W'(MapBits) : num_elements_q;
  assign nw_calc = bffl_pkg::SCAN_W'((12'(lim) + 12'd63) >> bffl_pkg::OFF_W);

  // set/get word select; index 0 is the msb of word 0
  assign in_range = 32'(index_i[bffl_pkg::IDX_W-1:bffl_pkg::OFF_W]) < NUM_WORDS;
  assign bit_mask = {1'b1, {(bffl_pkg::WORD_W-1){1'b0}}} >> idx_q[bffl_pkg::OFF_W-1:0];
  assign sel_bit  = |(mem_rdata & bit_mask);

  // search walks up from word 0 or down from the last word in range
  assign from_last = (kind_q == bffl_pkg::KIND_FIND_LAST);
  assign scan_word = from_last ? (nw_q - 6'd1 - iss_q) : iss_q;
  assign terminal  = chk_v_q && (srch_res.hit || chk_last_q);

  assign srch_req.value     = val_q;
  assign srch_req.from_last = from_last;
  assign srch_req.part      = chk_part_q ? part_q : '0;

  bffl_word_search u_search (
    .word_i (mem_rdata),
    .req_i  (srch_req),
    .res_o  (srch_res)
  );

  bffl_mem #(
    .DEPTH (NUM_WORDS),
    .AW    (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // state register and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= bffl_pkg::ST_INIT;
      cnt_q          <= '0;
      iss_q          <= '0;
      chk_v_q        <= 1'b0;
      out_valid_q    <= 1'b0;
      num_elements_q <= 11'd1024;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iss_q       <= iss_d;
      chk_v_q     <= chk_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_elements_q <= cfg_num_elements_i;
      end
    end
  end

  // item, search and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q  <= kind_i;
      idx_q   <= index_i;
      val_q   <= value_i;
      range_q <= in_range;
      nw_q    <= nw_calc;
      part_q  <= lim[bffl_pkg::OFF_W-1:0];
    end
    chk_w_q    <= chk_w_d;
    chk_last_q <= chk_last_d;
    chk_part_q <= chk_part_d;
    if (out_load) begin
      bit_res_q  <= res_bit;
      found_q    <= res_found;
      position_q <= res_pos;
    end
  end

  // next state, memory access and result
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    iss_d      = iss_q;
    chk_v_d    = chk_v_q;
    chk_w_d    = chk_w_q;
    chk_last_d = chk_last_q;
    chk_part_d = chk_part_q;
    mem_we     = 1'b0;
    mem_waddr  = cnt_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = AddrW'(index_i[bffl_pkg::IDX_W-1:bffl_pkg::OFF_W]);
    out_load   = 1'b0;
    res_bit    = 1'b0;
    res_found  = 1'b0;
    res_pos    = '0;

    case (state_q)
      bffl_pkg::ST_INIT: begin
        // clearing pass, one word a cycle
        mem_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == AddrW'(NUM_WORDS - 1)) begin
          cnt_d   = '0;
          state_d = bffl_pkg::ST_IDLE;
        end
      end
      bffl_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (kind_i)
            bffl_pkg::KIND_SET, bffl_pkg::KIND_GET: begin
              mem_re  = 1'b1;
              state_d = bffl_pkg::ST_RMW;
            end
            bffl_pkg::KIND_FILL: begin
              cnt_d   = '0;
              state_d = bffl_pkg::ST_FILL;
            end
            bffl_pkg::KIND_FIND_FIRST, bffl_pkg::KIND_FIND_LAST: begin
              iss_d   = '0;
              chk_v_d = 1'b0;
              state_d = (nw_calc == '0) ? bffl_pkg::ST_RESP : bffl_pkg::ST_SEARCH;
            end
            default: begin
              state_d = bffl_pkg::ST_RESP;
            end
          endcase
        end
      end
      bffl_pkg::ST_RMW: begin
        // read data of the addressed word is here; write back and answer together
        if (out_free) begin
          out_load  = 1'b1;
          res_bit   = (kind_q == bffl_pkg::KIND_GET) && range_q && sel_bit;
          mem_we    = (kind_q == bffl_pkg::KIND_SET) && range_q;
          mem_waddr = AddrW'(idx_q[bffl_pkg::IDX_W-1:bffl_pkg::OFF_W]);
          mem_wdata = val_q ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
          state_d   = bffl_pkg::ST_IDLE;
        end
      end
      bffl_pkg::ST_FILL: begin
        mem_wdata = {bffl_pkg::WORD_W{val_q}};
        if (cnt_q == AddrW'(NUM_WORDS - 1)) begin
          // last word goes with the result
          if (out_free) begin
            mem_we   = 1'b1;
            out_load = 1'b1;
            cnt_d    = '0;
            state_d  = bffl_pkg::ST_IDLE;
          end
        end else begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      bffl_pkg::ST_SEARCH: begin
        if (terminal) begin
          // hold the checked word until the result register frees
          if (out_free) begin
            out_load  = 1'b1;
            res_found = srch_res.hit;
            res_pos   = srch_res.hit ? {chk_w_q[WselW-1:0], srch_res.offset} : '0;
            chk_v_d   = 1'b0;
            state_d   = bffl_pkg::ST_IDLE;
          end
        end else begin
          // read the next word while checking the one read last cycle
          mem_re     = 1'b1;
          mem_raddr  = AddrW'(scan_word);
          iss_d      = iss_q + 1'b1;
          chk_v_d    = 1'b1;
          chk_w_d    = scan_word;
          chk_last_d = (iss_q == nw_q - 6'd1);
          chk_part_d = (scan_word == nw_q - 6'd1) && (part_q != '0);
        end
      end
      bffl_pkg::ST_RESP: begin
        // not found, or a kind with no effect
        if (out_free) begin
          out_load = 1'b1;
          state_d  = bffl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bffl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bit_res_o   = bit_res_q;
  assign found_o     = found_q;
  assign position_o  = position_q;

  // a search never writes the map
  `BFFL_ASSERT(a_search_no_write, clk_i, rst_ni, (state_q == bffl_pkg::ST_SEARCH) |-> !mem_we, "map written during a search")
  // a result is only loaded over an empty or departing one
  `BFFL_ASSERT(a_load_free, clk_i, rst_ni, out_load |-> (!out_valid_q || !out_stall_i), "result overwritten while stalled")
  // get and search results never both report
  `BFFL_ASSERT(a_found_no_bit, clk_i, rst_ni, (out_valid_o && found_o) |-> !bit_res_o, "bit_res and found both set")
  // a hit comes from a word inside the search range
  `BFFL_ASSERT(a_hit_in_range, clk_i, rst_ni, (out_load && res_found) |-> (chk_w_q < nw_q), "hit outside search range")
  // nothing enters while the map is being cleared
  `BFFL_ASSERT_ALWAYS(a_init_stall, clk_i, (state_q == bffl_pkg::ST_INIT) |-> (in_stall_o && !out_load), "activity during clearing pass")

endmodule
